FILE: src/mcwd_pkg.sv
// shared types, constants and helpers of the multichannel watchdog warning core
// no dependencies; imported by every module of the block
package mcwd_pkg;

  // number of software channels held in the deadline store
  localparam int CHANNELS = 8;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W    = $clog2(CHANNELS + 1);

  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 31;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WARNING_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINED_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINED_CHANNEL = 2'd3;

  // request commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] channel;
  } in_item_t;

  typedef struct packed {
    logic       warning;
    logic [2:0] warning_channel;
    logic       hw_feed;
    logic [2:0] hw_feed_channel;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] warning_period;
    logic [3:0]          channel_count;
    logic                combined_mode;
    logic [2:0]          combined_channel;
  } cfg_t;

  // deadline store access from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [TIME_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } dl_req_t;

  // wrap-safe time compare: a is at or after b
  function automatic logic reached(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return ~d[TIME_W-1];
  endfunction

endpackage

FILE: src/mcwd_dl_ram.sv
// deadline store: one write port, one registered read port
// depends on mcwd_pkg; entries never written since reset read as zero
module mcwd_dl_ram (
  input  logic                      clk,
  input  logic                      rst,
  input  mcwd_pkg::dl_req_t         req,
  output logic [mcwd_pkg::TIME_W-1:0] rdata
);
  import mcwd_pkg::*;

  logic [TIME_W-1:0]   mem [CHANNELS];
  logic [CHANNELS-1:0] vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= vld[req.raddr] ? mem[req.raddr] : '0;
  end

  // per-entry written flags stand in for the all-zero reset of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

endmodule

FILE: src/mcwd_ctrl.sv
// request sequencer: time base, alarm, fed marks and deadline walks
// depends on mcwd_pkg; drives the deadline store in mcwd_dl_ram
module mcwd_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  mcwd_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mcwd_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mcwd_pkg::out_item_t         out_data,
  output mcwd_pkg::dl_req_t           ram_req,
  input  logic [mcwd_pkg::TIME_W-1:0] ram_rdata
);
  import mcwd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_ALARM = 6'b000100,
    S_FILL  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t              state;
  logic [1:0]          cmd_q;
  logic [2:0]          ch_q;
  logic [TIME_W-1:0]   now_ticks;
  logic [TIME_W-1:0]   alarm_time;
  logic                alarm_armed;
  logic                running;
  logic [CHANNELS-1:0] fed_marks;
  logic [CNT_W-1:0]    issue_idx;
  logic [CNT_W-1:0]    eval_idx;
  logic [CNT_W-1:0]    scan_len;
  logic                pend;
  logic                mode_find;
  logic                found;
  logic [TIME_W-1:0]   best;
  out_item_t           res;

  logic [CNT_W-1:0]    n_act;
  logic [CHANNELS-1:0] act_mask;
  logic [CHANNELS-1:0] mark_set;
  logic [CHANNELS-1:0] marks_next;
  logic                all_fed;
  logic                ch_ok;
  logic [TIME_W-1:0]   new_dl;
  logic                issue;

  assign n_act = (32'(cfg.channel_count) > CHANNELS) ? CNT_W'(CHANNELS)
                                                     : CNT_W'(cfg.channel_count);
  assign ch_ok  = (32'(ch_q) < CHANNELS);
  assign new_dl = now_ticks + {1'b0, cfg.warning_period};
  assign issue  = (issue_idx < scan_len);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    mark_set = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      act_mask[i] = (i < 32'(n_act));
    end
    if (32'(ch_q) < 32'(n_act)) begin
      mark_set[IDX_W'(ch_q)] = 1'b1;
    end
    marks_next = fed_marks | mark_set;
    all_fed    = (marks_next == act_mask);
  end

  // store port: feed refresh, start fill, reads during the walk
  always_comb begin
    ram_req       = '0;
    ram_req.raddr = issue_idx[IDX_W-1:0];
    if (state == S_EXEC && cmd_q == CMD_FEED && running && ch_ok) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = IDX_W'(ch_q);
      ram_req.wdata = new_dl;
    end else if (state == S_FILL && issue_idx < n_act) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = issue_idx[IDX_W-1:0];
      ram_req.wdata = new_dl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      now_ticks   <= '0;
      alarm_time  <= '0;
      alarm_armed <= 1'b0;
      running     <= 1'b0;
      fed_marks   <= '0;
      issue_idx   <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // result register: loaded when the sequencer finishes, cleared once taken
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= in_data.command;
            ch_q  <= in_data.channel;
            res   <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          issue_idx <= '0;
          eval_idx  <= '0;
          pend      <= 1'b0;
          found     <= 1'b0;
          case (cmd_q)
            CMD_TICK: begin
              now_ticks <= now_ticks + 32'd1;
              state     <= S_ALARM;
            end
            CMD_FEED: begin
              if (!cfg.combined_mode) begin
                res.hw_feed         <= 1'b1;
                res.hw_feed_channel <= ch_q;
              end
              if (running) begin
                if (cfg.combined_mode) begin
                  if (all_fed) begin
                    res.hw_feed         <= 1'b1;
                    res.hw_feed_channel <= cfg.combined_channel;
                    fed_marks           <= '0;
                  end else begin
                    fed_marks <= marks_next;
                  end
                end
                if (n_act == '0) begin
                  alarm_armed <= 1'b0;
                  state       <= S_DONE;
                end else begin
                  mode_find <= 1'b0;
                  scan_len  <= n_act;
                  state     <= S_SCAN;
                end
              end else begin
                state <= S_DONE;
              end
            end
            CMD_START: begin
              running <= 1'b1;
              state   <= S_FILL;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_ALARM: begin
          if (alarm_armed && reached(now_ticks, alarm_time)) begin
            alarm_armed <= 1'b0;
            res.warning <= 1'b1;
            mode_find   <= 1'b1;
            scan_len    <= n_act;
            state       <= S_SCAN;
          end else begin
            state <= S_DONE;
          end
        end
        S_FILL: begin
          if (issue_idx < n_act) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end else begin
            // alarm goes to channel 0's deadline, whatever it holds
            issue_idx <= '0;
            scan_len  <= CNT_W'(1);
            mode_find <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            issue_idx <= issue_idx + CNT_W'(1);
          end
          pend <= issue;
          if (pend) begin
            eval_idx <= eval_idx + CNT_W'(1);
            if (mode_find) begin
              if (!found && reached(now_ticks, ram_rdata)) begin
                found               <= 1'b1;
                res.warning_channel <= 3'(eval_idx);
              end
            end else if (eval_idx == '0 || !reached(ram_rdata, best)) begin
              best <= ram_rdata;
            end
          end
          if (!issue && !pend) begin
            if (!mode_find) begin
              alarm_time  <= best;
              alarm_armed <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/multichannel_watchdog_warning_core.sv
// top level of the multichannel watchdog warning core: configuration registers
// depends on mcwd_pkg, mcwd_ctrl and mcwd_dl_ram
//
// usage
//   request channel (in_valid/in_ready/in_data): tick, feed of a channel, or start
//   result channel (out_valid/out_ready/out_data): exactly one result per request,
//     carrying the warning flag and channel and the hardware feed request
//   config port (cfg_we/cfg_index/cfg_wdata): warning period, channel count,
//     combined mode and combined feed channel; written only while the core is idle
//
// timing (n = active channel count, capped at CHANNELS; cycles from the edge that
// takes a request to the edge that raises out_valid)
//   one request at a time; in_ready is high only while the sequencer is idle
//   tick without alarm: 3; tick that fires the alarm: n + 5 (4 with no channels)
//   feed while running: n + 4 (2 with no channels); other feeds, unused codes: 2
//   start: n + 6 (fill of n deadlines, then read of channel 0)
//   the walks are set by the single read port of the deadline store:
//   one entry per cycle with a one-cycle read latency
// reset clears time, alarm, running flag, fed marks and the result valid;
// the deadline store reads as zero through per-entry written flags
// a stalled receiver holds the result register; a finished result then waits
// in the sequencer and no new request is taken until it moves out
module multichannel_watchdog_warning_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mcwd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mcwd_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [mcwd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcwd_pkg::CFG_W-1:0]     cfg_wdata
);
  import mcwd_pkg::*;

  cfg_t              cfg;
  dl_req_t           ram_req;
  logic [TIME_W-1:0] ram_rdata;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warning_period   <= PERIOD_RESET;
      cfg.channel_count    <= '0;
      cfg.combined_mode    <= 1'b0;
      cfg.combined_channel <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WARNING_PERIOD:   cfg.warning_period   <= cfg_wdata[PERIOD_W-1:0];
        REG_CHANNEL_COUNT:    cfg.channel_count    <= cfg_wdata[3:0];
        REG_COMBINED_MODE:    cfg.combined_mode    <= cfg_wdata[0];
        REG_COMBINED_CHANNEL: cfg.combined_channel <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  // sequencer: owns time base, alarm and the deadline walks
  mcwd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // per-channel deadlines
  mcwd_dl_ram u_dl_ram (
    .clk   (clk),
    .rst   (rst),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // one request in flight: a taken request drops ready on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  // warnings come only from ticks, hardware feeds only from feeds
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.warning && out_data.hw_feed))
    else $error("warning and hardware feed in one result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.warning |-> out_data.warning_channel == 3'd0)
    else $error("warning channel set without a warning");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hw_feed |-> out_data.hw_feed_channel == 3'd0)
    else $error("feed channel set without a hardware feed");

endmodule

FILE: bench/mcwd_checker.sv
`timescale 1ns / 100ps
// result checker of the multichannel watchdog warning core: follows the register port,
// predicts one result per accepted request and compares it; depends on mcwd_pkg
module mcwd_checker
  import mcwd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  logic [PERIOD_W-1:0] period_reg;
  logic [3:0]          count_reg;
  logic                combined_reg;
  logic [2:0]          global_reg;

  logic [TIME_W-1:0]   now_ticks;
  logic [TIME_W-1:0]   chan_deadline [CHANNELS];
  logic [TIME_W-1:0]   alarm_at;
  logic                alarm_armed;
  logic                running;
  logic [CHANNELS-1:0] fed_marks;

  out_item_t           pending_outcomes [$];

  // wrap-safe: a is at or after b
  function automatic logic at_or_after(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return !d[TIME_W-1];
  endfunction

  function automatic out_item_t watchdog_outcome(in_item_t req);
    out_item_t           res;
    int                  n;
    int                  ch;
    int                  i;
    logic                found;
    logic [CHANNELS-1:0] mask;
    logic [TIME_W-1:0]   best;
    res   = '0;
    n     = (int'(count_reg) > CHANNELS) ? CHANNELS : int'(count_reg);
    ch    = int'(req.channel);
    found = 1'b0;
    mask  = '0;
    for (i = 0; i < n; i++) mask[i] = 1'b1;
    case (req.command)
      CMD_TICK: begin
        now_ticks = now_ticks + 1;
        if (alarm_armed && at_or_after(now_ticks, alarm_at)) begin
          alarm_armed = 1'b0;
          res.warning = 1'b1;
          for (i = 0; i < n; i++) begin
            if (!found && at_or_after(now_ticks, chan_deadline[i])) begin
              res.warning_channel = 3'(i);
              found = 1'b1;
            end
          end
        end
      end
      CMD_FEED: begin
        if (!combined_reg) begin
          res.hw_feed         = 1'b1;
          res.hw_feed_channel = req.channel;
        end
        if (running) begin
          if (combined_reg) begin
            if (ch < n) fed_marks[ch] = 1'b1;
            if (fed_marks == mask) begin
              res.hw_feed         = 1'b1;
              res.hw_feed_channel = global_reg;
              fed_marks           = '0;
            end
          end
          if (ch < CHANNELS) chan_deadline[ch] = now_ticks + {1'b0, period_reg};
          if (n == 0) begin
            alarm_armed = 1'b0;
          end else begin
            best = chan_deadline[0];
            for (i = 1; i < n; i++) begin
              if (!at_or_after(chan_deadline[i], best)) best = chan_deadline[i];
            end
            alarm_at    = best;
            alarm_armed = 1'b1;
          end
        end
      end
      CMD_START: begin
        for (i = 0; i < n; i++) chan_deadline[i] = now_ticks + {1'b0, period_reg};
        alarm_at    = chan_deadline[0];
        alarm_armed = 1'b1;
        running     = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int want_val, input int seen_val);
    $display("%0t ns: %s: expected %0d, got %0d", $realtime, what, want_val, seen_val);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      period_reg   = PERIOD_RESET;
      count_reg    = '0;
      combined_reg = 1'b0;
      global_reg   = '0;
      now_ticks    = '0;
      for (int i = 0; i < CHANNELS; i++) chan_deadline[i] = '0;
      alarm_at     = '0;
      alarm_armed  = 1'b0;
      running      = 1'b0;
      fed_marks    = '0;
      pending_outcomes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WARNING_PERIOD:   period_reg   = cfg_wdata[PERIOD_W-1:0];
          REG_CHANNEL_COUNT:    count_reg    = cfg_wdata[3:0];
          REG_COMBINED_MODE:    combined_reg = cfg_wdata[0];
          REG_COMBINED_CHANNEL: global_reg   = cfg_wdata[2:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_outcomes.push_back(watchdog_outcome(in_data));
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with no request waiting", 0, int'(out_data));
        end else begin
          want = pending_outcomes.pop_front();
          if (out_data.warning !== want.warning)
            report_mismatch("warning", int'(want.warning), int'(out_data.warning));
          if (out_data.warning_channel !== want.warning_channel)
            report_mismatch("warning_channel", int'(want.warning_channel),
                            int'(out_data.warning_channel));
          if (out_data.hw_feed !== want.hw_feed)
            report_mismatch("hw_feed", int'(want.hw_feed), int'(out_data.hw_feed));
          if (out_data.hw_feed_channel !== want.hw_feed_channel)
            report_mismatch("hw_feed_channel", int'(want.hw_feed_channel),
                            int'(out_data.hw_feed_channel));
        end
      end
    end
    outstanding <= pending_outcomes.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// bench top of the multichannel watchdog warning core: clock, reset, requests, result
// stalls, register phases and verdict; depends on mcwd_pkg, mcwd_checker and the core
module testbench;
  import mcwd_pkg::*;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int DRAIN_CYCLES    = 40;
  // command code the core must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int ready_hold  = 0;
  // phase without any idling on either side
  bit steady      = 1'b0;
  // channel count as last written, capped like the core does
  int active_ch   = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multichannel_watchdog_warning_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mcwd_checker outcome_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // hard stop in case the core hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver side: ready stretches and stalls of random length
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 9) < 6) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // one request; valid stays high into the next request when there is no gap
  task automatic send_request(input logic [1:0] cmd, input logic [2:0] ch);
    int       gap;
    in_item_t req;
    gap         = pick_gap();
    req.command = cmd;
    req.channel = ch;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and let every expected result come out before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [PERIOD_W-1:0] period, input logic [3:0] count,
                           input logic combined, input logic [2:0] glob);
    write_reg(REG_WARNING_PERIOD, CFG_W'(period));
    write_reg(REG_CHANNEL_COUNT, CFG_W'(count));
    write_reg(REG_COMBINED_MODE, CFG_W'(combined));
    write_reg(REG_COMBINED_CHANNEL, CFG_W'(glob));
    active_ch = (int'(count) > CHANNELS) ? CHANNELS : int'(count);
  endtask

  initial begin
    int                  sent;
    int                  phase_len;
    int                  roll;
    int                  k;
    logic [PERIOD_W-1:0] period;
    logic [3:0]          count;
    logic [2:0]          ch;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: period 1000, no channels, pass-through
    send_request(CMD_FEED, 3'd7);      // feed before start: only forwarded
    send_request(CMD_UNUSED, 3'd5);    // ignored command, all-zero result
    send_request(CMD_TICK, 3'd0);
    send_request(CMD_START, 3'd0);     // no channels, still armed at deadline 0
    send_request(CMD_FEED, 3'd2);      // no channels: re-arm disarms
    send_request(CMD_TICK, 3'd0);
    wait_idle();

    // combined with no channels: every feed while running is a global feed
    configure(31'd1, 4'd0, 1'b1, 3'd7);
    send_request(CMD_FEED, 3'd0);
    send_request(CMD_START, 3'd0);
    send_request(CMD_TICK, 3'd0);      // fires with nothing expired
    wait_idle();

    // three channels combined, with a feed of an inactive channel in the round
    configure(31'd2, 4'd3, 1'b1, 3'd7);
    send_request(CMD_START, 3'd0);
    send_request(CMD_FEED, 3'd0);
    send_request(CMD_FEED, 3'd5);
    send_request(CMD_FEED, 3'd1);
    send_request(CMD_FEED, 3'd2);      // round complete
    send_request(CMD_TICK, 3'd0);
    send_request(CMD_TICK, 3'd0);
    send_request(CMD_TICK, 3'd0);
    wait_idle();

    // longest period, count above the store size
    configure(31'h7FFF_FFFF, 4'd15, 1'b0, 3'd0);
    send_request(CMD_START, 3'd0);
    send_request(CMD_FEED, 3'd7);
    send_request(CMD_TICK, 3'd0);
    send_request(CMD_FEED, 3'd0);
    wait_idle();

    // shortest period, all channels: re-arm at a time already reached
    configure(31'd1, 4'd8, 1'b1, 3'd3);
    send_request(CMD_START, 3'd0);
    send_request(CMD_TICK, 3'd0);
    send_request(CMD_FEED, 3'd3);
    send_request(CMD_TICK, 3'd0);

    // random phases: new settings, a start, then mostly ticks and feeds
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      wait_idle();
      steady = ($urandom_range(0, 4) == 0);

      roll = $urandom_range(0, 9);
      if (roll == 0) period = 31'h7FFF_FFFF;
      else if (roll < 3) period = 31'd1;
      else if (roll < 9) period = 31'($urandom_range(2, 24));
      else period = {1'b1, 30'($urandom())};
      roll = $urandom_range(0, 9);
      if (roll == 0) count = 4'd0;
      else if (roll == 1) count = 4'($urandom_range(9, 15));
      else if (roll < 4) count = 4'd8;
      else count = 4'($urandom_range(1, 7));
      configure(period, count, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));

      send_request(CMD_START, 3'($urandom_range(0, 7)));
      sent++;
      phase_len = $urandom_range(30, 120);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          send_request(CMD_TICK, 3'($urandom_range(0, 7)));
          sent++;
        end else if (roll < 88) begin
          // mostly active channels so combined rounds complete
          if (active_ch > 0 && $urandom_range(0, 99) < 85)
            ch = 3'($urandom_range(0, active_ch - 1));
          else
            ch = 3'($urandom_range(0, 7));
          send_request(CMD_FEED, ch);
          sent++;
        end else if (roll < 93) begin
          // a full round of feeds over the active channels
          for (k = 0; k < active_ch; k++) send_request(CMD_FEED, 3'(k));
          sent += active_ch;
        end else if (roll < 97) begin
          send_request(CMD_START, 3'($urandom_range(0, 7)));
          sent++;
        end else begin
          send_request(CMD_UNUSED, 3'($urandom_range(0, 7)));
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
